FILE: src/tcsm_pkg.sv
// ============================================================================
// TCP connection state machine package
// Shared types, codes and helper functions for the connection endpoint.
// ============================================================================
`default_nettype none

package tcsm_pkg;

    localparam logic [4:0] FL_FIN   = 5'h01;
    localparam logic [4:0] FL_SYN   = 5'h02;
    localparam logic [4:0] FL_RST   = 5'h04;
    localparam logic [4:0] FL_PSH   = 5'h08;
    localparam logic [4:0] FL_ACK   = 5'h10;
    localparam logic [4:0] FL_CTL   = FL_ACK | FL_RST | FL_SYN | FL_FIN;
    localparam logic [4:0] FL_NOACK = FL_RST | FL_SYN | FL_FIN;

    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_WRONG_STATE = 2'd1;
    localparam logic [1:0] STS_BUSY        = 2'd2;
    localparam logic [1:0] STS_NO_BUF      = 2'd3;

    localparam logic [2:0] APP_NONE      = 3'd0;
    localparam logic [2:0] APP_CONNECTED = 3'd1;
    localparam logic [2:0] APP_DELIVERED = 3'd2;
    localparam logic [2:0] APP_SEND_ACK  = 3'd3;
    localparam logic [2:0] APP_BAD_PORT  = 3'd4;

    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    localparam logic [1:0] REG_LISTEN_PORT   = 2'd0;
    localparam logic [1:0] REG_LISTEN_ENABLE = 2'd1;
    localparam logic [1:0] REG_INITIAL_SEQ   = 2'd2;

    localparam logic [15:0] LISTEN_PORT_RESET = 16'd7;

    typedef enum logic [2:0] {
        OP_CONNECT   = 3'd0,
        OP_SEND      = 3'd1,
        OP_SEND_DONE = 3'd2,
        OP_RECEIVE   = 3'd3,
        OP_CLOSE     = 3'd4,
        OP_TIMEOUT   = 3'd5
    } t_opcode;

    typedef enum logic [20:0] {
        ST_CLOSED       = 21'h000001,
        ST_A_SYN_RCVD   = 21'h000002,
        ST_SYN_RCVD     = 21'h000004,
        ST_A_SYN_SENT   = 21'h000008,
        ST_SYN_SENT     = 21'h000010,
        ST_A_ESTAB      = 21'h000020,
        ST_ESTAB        = 21'h000040,
        ST_A_DATA_SENT  = 21'h000080,
        ST_DATA_SENT    = 21'h000100,
        ST_A_DATA_RCVD  = 21'h000200,
        ST_A_FIN_WAIT_1 = 21'h000400,
        ST_FIN_WAIT_1   = 21'h000800,
        ST_A_CLOSING    = 21'h001000,
        ST_CLOSING      = 21'h002000,
        ST_FIN_WAIT_2   = 21'h004000,
        ST_A_TIME_WAIT  = 21'h008000,
        ST_TIME_WAIT    = 21'h010000,
        ST_A_CLOSE_WAIT = 21'h020000,
        ST_CLOSE_WAIT   = 21'h040000,
        ST_A_LAST_ACK   = 21'h080000,
        ST_LAST_ACK     = 21'h100000
    } t_state;

    typedef struct packed {
        logic [15:0] listen_port;
        logic        listen_enable;
        logic [31:0] initial_seq;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] near_port;
        logic [15:0] far_port;
        logic [31:0] seg_seq;
        logic [4:0]  seg_flags;
        logic [15:0] payload_len;
        logic        buffer_ok;
    } t_item;

    typedef struct packed {
        t_state      state;
        logic [31:0] own_seq;
        logic [31:0] peer_next_seq;
        logic [15:0] own_port;
        logic [15:0] peer_port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        send_pending;
        logic        recv_pending;
        logic        timer_running;
    } t_conn;

    typedef struct packed {
        logic        emit;
        logic [4:0]  flags;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
    } t_hdr;

    typedef struct packed {
        logic [1:0] status;
        t_hdr       hdr;
        logic [4:0] conn_now;
        logic [2:0] app_event;
        logic [1:0] timer_cmd;
    } t_result;

    // The connection drops back to closed; the local port and timer survive.
    function automatic t_conn conn_rst(input t_conn cur, input logic [31:0] init_seq);
        t_conn c;
        c               = cur;
        c.state         = ST_CLOSED;
        c.own_seq       = init_seq;
        c.peer_next_seq = '0;
        c.peer_port     = '0;
        c.addr_high     = '0;
        c.addr_low      = '0;
        c.send_pending  = 1'b0;
        c.recv_pending  = 1'b0;
        return c;
    endfunction

    function automatic t_hdr mk_hdr(input logic [4:0] flags, input t_conn c);
        t_hdr h;
        h.emit     = 1'b1;
        h.flags    = flags;
        h.src_port = c.own_port;
        h.dst_port = c.peer_port;
        h.seq      = c.own_seq;
        h.ack      = ((flags & FL_ACK) != '0) ? c.peer_next_seq : '0;
        return h;
    endfunction

    function automatic logic [2:0] app_sel(input logic [2:0] ev, input logic [15:0] own_port,
                                           input logic [15:0] listen_port);
        return (own_port == listen_port) ? ev : APP_BAD_PORT;
    endfunction

    function automatic logic [4:0] state_index(input t_state s);
        logic [4:0] idx;
        unique case (s)
            ST_CLOSED:       idx = 5'd0;
            ST_A_SYN_RCVD:   idx = 5'd1;
            ST_SYN_RCVD:     idx = 5'd2;
            ST_A_SYN_SENT:   idx = 5'd3;
            ST_SYN_SENT:     idx = 5'd4;
            ST_A_ESTAB:      idx = 5'd5;
            ST_ESTAB:        idx = 5'd6;
            ST_A_DATA_SENT:  idx = 5'd7;
            ST_DATA_SENT:    idx = 5'd8;
            ST_A_DATA_RCVD:  idx = 5'd9;
            ST_A_FIN_WAIT_1: idx = 5'd10;
            ST_FIN_WAIT_1:   idx = 5'd11;
            ST_A_CLOSING:    idx = 5'd12;
            ST_CLOSING:      idx = 5'd13;
            ST_FIN_WAIT_2:   idx = 5'd14;
            ST_A_TIME_WAIT:  idx = 5'd15;
            ST_TIME_WAIT:    idx = 5'd16;
            ST_A_CLOSE_WAIT: idx = 5'd17;
            ST_CLOSE_WAIT:   idx = 5'd18;
            ST_A_LAST_ACK:   idx = 5'd19;
            ST_LAST_ACK:     idx = 5'd20;
            default:         idx = 5'd0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: src/tcsm_event_logic.sv
// ============================================================================
// TCP connection event logic
// Computes the next connection context and the result for one event.
// ============================================================================
`default_nettype none

module tcsm_event_logic
    import tcsm_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  t_conn   i_cur,
    output t_conn   o_nxt,
    output t_result o_res
);

    t_conn   c;
    t_result r;
    logic    listen;
    logic    filtered;
    logic    ok;
    logic [4:0]  f;
    logic [31:0] len32;

    always_comb begin
        c        = i_cur;
        r        = '0;
        ok       = i_item.buffer_ok;
        f        = i_item.seg_flags;
        len32    = {16'b0, i_item.payload_len};
        listen   = (i_item.near_port == i_cfg.listen_port) && i_cfg.listen_enable;
        filtered = (i_cur.state != ST_CLOSED) &&
                   ((i_item.near_port != i_cur.own_port) ||
                    (i_item.far_port != i_cur.peer_port) ||
                    (i_item.addr_high != i_cur.addr_high) ||
                    (i_item.addr_low != i_cur.addr_low));

        unique case (t_opcode'(i_item.opcode))
            OP_CONNECT: begin
                if (c.state != ST_CLOSED) begin
                    r.status = STS_WRONG_STATE;
                end else begin
                    c.own_port  = i_item.near_port;
                    c.peer_port = i_item.far_port;
                    c.addr_high = i_item.addr_high;
                    c.addr_low  = i_item.addr_low;
                    if (!ok) begin
                        r.status = STS_NO_BUF;
                    end else begin
                        c.own_seq = i_cfg.initial_seq;
                        r.hdr     = mk_hdr(FL_SYN, c);
                        c.state   = ST_A_SYN_SENT;
                    end
                end
            end
            OP_SEND: begin
                if (c.state != ST_ESTAB) begin
                    r.status = STS_WRONG_STATE;
                end else if (c.send_pending) begin
                    r.status = STS_BUSY;
                end else begin
                    c.send_pending = 1'b1;
                    r.hdr          = mk_hdr(FL_ACK | FL_PSH, c);
                    c.own_seq      = c.own_seq + len32;
                    c.state        = ST_A_DATA_SENT;
                end
            end
            OP_SEND_DONE: begin
                unique case (c.state)
                    ST_A_SYN_SENT:   c.state = ST_SYN_SENT;
                    ST_A_SYN_RCVD:   c.state = ST_SYN_RCVD;
                    ST_A_ESTAB: begin
                        c.state     = ST_ESTAB;
                        r.app_event = app_sel(APP_CONNECTED, c.own_port, i_cfg.listen_port);
                    end
                    ST_A_DATA_SENT:  c.state = ST_DATA_SENT;
                    ST_A_DATA_RCVD: begin
                        c.state        = ST_ESTAB;
                        r.app_event    = app_sel(APP_DELIVERED, c.own_port,
                                                 i_cfg.listen_port);
                        c.recv_pending = 1'b0;
                    end
                    ST_A_FIN_WAIT_1: c.state = ST_FIN_WAIT_1;
                    ST_A_CLOSING:    c.state = ST_CLOSING;
                    ST_A_TIME_WAIT:  c = conn_rst(c, i_cfg.initial_seq);
                    ST_A_CLOSE_WAIT: begin
                        c.state = ST_CLOSE_WAIT;
                        if (!ok) begin
                            r.status = STS_NO_BUF;
                        end else begin
                            r.hdr   = mk_hdr(FL_FIN | FL_ACK, c);
                            c.state = ST_A_LAST_ACK;
                        end
                    end
                    ST_A_LAST_ACK:   c.state = ST_LAST_ACK;
                    default:         r.status = STS_WRONG_STATE;
                endcase
            end
            OP_RECEIVE: begin
                if (!filtered) begin
                    if ((f & FL_RST) != '0) begin
                        c = conn_rst(c, i_cfg.initial_seq);
                    end else begin
                        unique case (c.state)
                            ST_CLOSED: begin
                                if (i_item.near_port != i_cfg.listen_port) begin
                                    r.app_event = APP_BAD_PORT;
                                end
                                if (((f & FL_CTL) == FL_SYN) && listen) begin
                                    c.own_port      = i_item.near_port;
                                    c.peer_next_seq = i_item.seg_seq + 32'd1;
                                    c.peer_port     = i_item.far_port;
                                    c.addr_high     = i_item.addr_high;
                                    c.addr_low      = i_item.addr_low;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr     = mk_hdr(FL_SYN | FL_ACK, c);
                                        c.own_seq = c.own_seq + 32'd1;
                                        c.state   = ST_A_SYN_RCVD;
                                    end
                                end else begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            ST_SYN_SENT: begin
                                if ((f & FL_CTL) == (FL_SYN | FL_ACK)) begin
                                    c.peer_next_seq = i_item.seg_seq + 32'd1;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr   = mk_hdr(FL_ACK, c);
                                        c.state = ST_A_ESTAB;
                                    end
                                end else if ((f & FL_CTL) == FL_SYN) begin
                                    c.peer_next_seq = i_item.seg_seq + 32'd1;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr     = mk_hdr(FL_SYN | FL_ACK, c);
                                        c.own_seq = c.own_seq + 32'd1;
                                        c.state   = ST_A_SYN_RCVD;
                                    end
                                end else begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            ST_SYN_RCVD: begin
                                if ((f & FL_CTL) == FL_ACK) begin
                                    c.state = ST_ESTAB;
                                end else begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            ST_ESTAB: begin
                                if ((f & FL_NOACK) == FL_FIN) begin
                                    c.peer_next_seq = i_item.seg_seq + len32 + 32'd1;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr   = mk_hdr(FL_ACK, c);
                                        c.state = ST_A_CLOSE_WAIT;
                                    end
                                end else if ((f & FL_NOACK) == '0) begin
                                    c.peer_next_seq = i_item.seg_seq + len32;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr          = mk_hdr(FL_ACK, c);
                                        c.recv_pending = 1'b1;
                                        c.state        = ST_A_DATA_RCVD;
                                    end
                                end else begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            ST_DATA_SENT: begin
                                if ((f & FL_CTL) == FL_ACK) begin
                                    r.app_event    = app_sel(APP_SEND_ACK, c.own_port,
                                                             i_cfg.listen_port);
                                    c.send_pending = 1'b0;
                                    c.state        = ST_ESTAB;
                                end else if ((f & FL_NOACK) == FL_FIN) begin
                                    r.app_event     = app_sel(APP_SEND_ACK, c.own_port,
                                                              i_cfg.listen_port);
                                    c.send_pending  = 1'b0;
                                    c.peer_next_seq = i_item.seg_seq + len32 + 32'd1;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr   = mk_hdr(FL_ACK, c);
                                        c.state = ST_A_CLOSE_WAIT;
                                    end
                                end else begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            ST_FIN_WAIT_1: begin
                                if (((f & FL_CTL) == FL_FIN) ||
                                    ((f & FL_CTL) == (FL_FIN | FL_ACK))) begin
                                    c.peer_next_seq = i_item.seg_seq + 32'd1;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr = mk_hdr(FL_ACK, c);
                                        if ((f & FL_ACK) != '0) begin
                                            c.state = ST_A_TIME_WAIT;
                                        end else begin
                                            c.state = ST_A_CLOSING;
                                        end
                                    end
                                end else if ((f & FL_CTL) == FL_ACK) begin
                                    c.state = ST_FIN_WAIT_2;
                                end else begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            ST_FIN_WAIT_2: begin
                                if ((f & FL_NOACK) == FL_FIN) begin
                                    c.peer_next_seq = i_item.seg_seq + 32'd1;
                                    if (!ok) begin
                                        r.status = STS_NO_BUF;
                                    end else begin
                                        r.hdr   = mk_hdr(FL_ACK, c);
                                        c.state = ST_A_TIME_WAIT;
                                    end
                                end
                            end
                            ST_CLOSING, ST_LAST_ACK: begin
                                if ((f & FL_CTL) == FL_ACK) begin
                                    c = conn_rst(c, i_cfg.initial_seq);
                                end
                            end
                            default: r.status = STS_WRONG_STATE;
                        endcase
                    end
                end
            end
            OP_CLOSE: begin
                if (!((c.state == ST_A_CLOSE_WAIT) || (c.state == ST_CLOSE_WAIT) ||
                      (c.state == ST_A_LAST_ACK) || (c.state == ST_LAST_ACK) ||
                      (c.state == ST_CLOSED))) begin
                    if (!ok) begin
                        r.status = STS_NO_BUF;
                    end else begin
                        r.hdr     = mk_hdr(FL_FIN | FL_ACK, c);
                        c.own_seq = c.own_seq + 32'd1;
                        c.state   = ST_A_FIN_WAIT_1;
                    end
                end
            end
            OP_TIMEOUT: c = conn_rst(c, i_cfg.initial_seq);
            default: r.status = STS_OK;
        endcase

        if (c.state == ST_CLOSED) begin
            if (c.timer_running) begin
                r.timer_cmd     = TMR_STOP;
                c.timer_running = 1'b0;
            end
        end else if (!c.timer_running) begin
            r.timer_cmd     = TMR_START;
            c.timer_running = 1'b1;
        end

        r.conn_now = state_index(c.state);
    end

    assign o_nxt = c;
    assign o_res = r;

endmodule

`default_nettype wire

FILE: src/tcsm_cfg_regs.sv
// ============================================================================
// TCP connection configuration registers
// Holds the listen port, listen enable and initial sequence number.
// ============================================================================
`default_nettype none

module tcsm_cfg_regs
    import tcsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LISTEN_PORT:   n_cfg.listen_port   = i_cfg_data[15:0];
                REG_LISTEN_ENABLE: n_cfg.listen_enable = i_cfg_data[0];
                REG_INITIAL_SEQ:   n_cfg.initial_seq   = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_port   <= LISTEN_PORT_RESET;
            r_cfg.listen_enable <= 1'b1;
            r_cfg.initial_seq   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/tcp_connection_state_machine.sv
// ============================================================================
// TCP connection state machine
// Single-connection TCP endpoint: one event in, one result beat out.
// ============================================================================
// Usage:
// The event channel (i_in_valid / o_in_stall) takes one event per beat into an
// input register. From there the event is decoded against the connection
// context and its result is written into the output register, which drives
// the result channel (o_out_valid / i_out_stall). Every event gives exactly
// one result beat.
// The block sustains one event per cycle while the receiver does not stall.
// The connection context updates in the same cycle the result is registered,
// so an event always sees the effect of the one before it.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more event and then stalls the sender.
// The configuration port is a plain write port and must be written only while
// no event is in flight; the block does not check it. Synchronous active-low
// reset closes the connection, empties both registers, restores config defaults.
// ============================================================================
`default_nettype none

module tcp_connection_state_machine
    import tcsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [63:0] i_addr_high,
    input  wire logic [63:0] i_addr_low,
    input  wire logic [15:0] i_near_port,
    input  wire logic [15:0] i_far_port,
    input  wire logic [31:0] i_seg_seq,
    input  wire logic [4:0]  i_seg_flags,
    input  wire logic [15:0] i_payload_len,
    input  wire logic        i_buffer_ok,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_emit,
    output logic [4:0]       o_out_flags,
    output logic [15:0]      o_out_src_port,
    output logic [15:0]      o_out_dst_port,
    output logic [31:0]      o_out_seq,
    output logic [31:0]      o_out_ack,
    output logic [4:0]       o_conn_now,
    output logic [2:0]       o_app_event,
    output logic [1:0]       o_timer_cmd
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_conn   r_conn;
    t_conn   n_conn;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    advance;
    logic    load;

    tcsm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcsm_event_logic u_event_logic (
        .i_cfg  (cfg),
        .i_item (r_item),
        .i_cur  (r_conn),
        .o_nxt  (n_conn),
        .o_res  (n_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn.state         <= ST_CLOSED;
            r_conn.own_seq       <= '0;
            r_conn.peer_next_seq <= '0;
            r_conn.own_port      <= '0;
            r_conn.peer_port     <= '0;
            r_conn.addr_high     <= '0;
            r_conn.addr_low      <= '0;
            r_conn.send_pending  <= 1'b0;
            r_conn.recv_pending  <= 1'b0;
            r_conn.timer_running <= 1'b0;
        end else if (advance) begin
            r_conn <= n_conn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.opcode      <= i_opcode;
            r_item.addr_high   <= i_addr_high;
            r_item.addr_low    <= i_addr_low;
            r_item.near_port   <= i_near_port;
            r_item.far_port    <= i_far_port;
            r_item.seg_seq     <= i_seg_seq;
            r_item.seg_flags   <= i_seg_flags;
            r_item.payload_len <= i_payload_len;
            r_item.buffer_ok   <= i_buffer_ok;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_res.status;
    assign o_emit         = r_res.hdr.emit;
    assign o_out_flags    = r_res.hdr.flags;
    assign o_out_src_port = r_res.hdr.src_port;
    assign o_out_dst_port = r_res.hdr.dst_port;
    assign o_out_seq      = r_res.hdr.seq;
    assign o_out_ack      = r_res.hdr.ack;
    assign o_conn_now     = r_res.conn_now;
    assign o_app_event    = r_res.app_event;
    assign o_timer_cmd    = r_res.timer_cmd;

`ifndef ASSERT_OFF
    a_hdr_zero_without_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_emit) |-> (o_out_flags == '0 && o_out_seq == '0 &&
                                      o_out_ack == '0))
        else $error("header fields set on a beat without a segment");

    a_ack_zero_without_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_flags & FL_ACK) == '0) |-> (o_out_ack == '0))
        else $error("acknowledgement number set without ACK flag");

    a_advance_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed event produced no result beat");

    a_timer_stop_when_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timer_cmd == TMR_STOP) |-> (o_conn_now == state_index(ST_CLOSED)))
        else $error("timer stopped while the connection is open");
`endif

endmodule

`default_nettype wire
